// ===== design/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 48;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic      enqueue;
      logic      dequeue;
      value_type new_value;
   } cmd_type;

endpackage

// ===== design/spq_cell.sv =====
// One slot of the sorted row: keeps, takes the new value, or shifts from a neighbor.
module spq_cell (
   input  logic              clock,
   input  spq_pkg::cmd_type  cmd,
   input  logic              slot_valid,
   input  logic              left_greater,
   input  spq_pkg::value_type left_value,
   input  spq_pkg::value_type right_value,
   output logic              greater,
   output spq_pkg::value_type value
);
   import spq_pkg::*;

   value_type value_ff;
   value_type value_in;

   assign greater = slot_valid && (value_ff > cmd.new_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.enqueue) begin
         if (!greater) begin
            value_in = left_greater ? cmd.new_value : left_value;
         end
      end else if (cmd.dequeue) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== design/sorted_priority_queue.sv =====
// The result of an item is registered in the output register as the item is accepted.
// Throughput: one item per cycle; every cell of the row updates in the same cycle.
// The output register is refilled while its item is taken, so the block stalls only
// when a result is not taken.
// Reset clears the entry count and the output valid flag; the output data and the cell contents are not reset.
module sorted_priority_queue #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: new_value[31:0].
   input  logic [spq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0: kind.
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: out_value[31:0], status[33:32], entry_count[38:34],
   // is_empty[39], is_full[40], zeros above.
   output logic [spq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Fields from bit 0: out_valid.
   output logic                             rsp_tuser
);
   import spq_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic             rsp_user_ff;
   logic             rsp_user_in;

   logic             accept;
   logic             is_full_now;
   logic             is_empty_now;
   logic             is_full_next;
   logic             is_empty_next;
   logic [STATUS_W-1:0] status;
   value_type        out_value;
   logic             out_valid;
   logic [CNT_W+COUNT_W-1:0] count_wide;
   cmd_type          cmd;

   logic      [QUEUE_DEPTH-1:0] slot_valid;
   logic      [QUEUE_DEPTH-1:0] greater;
   value_type                   cell_value [QUEUE_DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign is_full_now = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty_now = (count_ff == '0);

   assign cmd.enqueue = accept && (req_tuser == KIND_ENQUEUE) && !is_full_now;
   assign cmd.dequeue = accept && (req_tuser == KIND_DEQUEUE) && !is_empty_now;
   assign cmd.new_value = value_type'(req_tdata[VALUE_W-1:0]);

   always_comb begin
      count_in = count_ff;
      if (cmd.enqueue) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dequeue) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign is_full_next = (count_in == CNT_W'(QUEUE_DEPTH));
   assign is_empty_next = (count_in == '0);
   assign count_wide = {{COUNT_W{1'b0}}, count_in};

   always_comb begin
      status = STATUS_OK;
      if (req_tuser == KIND_ENQUEUE && is_full_now) begin
         status = STATUS_FULL;
      end else if (req_tuser == KIND_DEQUEUE && is_empty_now) begin
         status = STATUS_EMPTY;
      end
   end

   assign out_valid = cmd.dequeue;
   assign out_value = cmd.dequeue ? cell_value[0] : '0;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_user_in = out_valid;
         rsp_data_in = {{(RSP_DATA_W - VALUE_W - STATUS_W - COUNT_W - 2){1'b0}},
                        is_full_next, is_empty_next, count_wide[COUNT_W-1:0],
                        status, out_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      left_greater;
      value_type left_value;
      value_type right_value;

      assign slot_valid[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_greater = 1'b1;
         assign left_value = '0;
      end else begin : g_body
         assign left_greater = greater[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .slot_valid   (slot_valid[i]),
         .left_greater (left_greater),
         .left_value   (left_value),
         .right_value  (right_value),
         .greater      (greater[i]),
         .value        (cell_value[i])
      );
   end

endmodule

// ===== test/sorted_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue: directed and random enqueue and dequeue items.
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct {
      value_type             out_value;
      logic                  out_valid;
      logic [STATUS_W-1:0]   status;
      logic [COUNT_W-1:0]    entry_count;
      logic                  is_empty;
      logic                  is_full;
   } queue_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = KIND_ENQUEUE;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;

   value_type       shadow_entries[$];
   queue_rsp_type   awaited_rsps[$];
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     cycle_count = 0;
   int unsigned     error_count = 0;
   int unsigned     items_sent = 0;
   int unsigned     rsps_checked = 0;
   int unsigned     full_refusals = 0;
   int unsigned     empty_refusals = 0;
   int unsigned     max_depth_hits = 0;

   sorted_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic queue_rsp_type apply_queue_op(input logic kind, input value_type value);
      queue_rsp_type rsp;
      int unsigned   pos;
      rsp = '{out_value: '0, out_valid: 1'b0, status: STATUS_OK, entry_count: '0,
              is_empty: 1'b0, is_full: 1'b0};
      pos = 0;
      if (kind == KIND_ENQUEUE) begin
         if (shadow_entries.size() >= DEPTH) begin
            rsp.status = STATUS_FULL;
            full_refusals++;
         end else begin
            while (pos < shadow_entries.size() && shadow_entries[pos] > value) pos++;
            shadow_entries.insert(pos, value);
            if (shadow_entries.size() == DEPTH) max_depth_hits++;
         end
      end else begin
         if (shadow_entries.size() == 0) begin
            rsp.status = STATUS_EMPTY;
            empty_refusals++;
         end else begin
            rsp.out_value = shadow_entries.pop_front();
            rsp.out_valid = 1'b1;
         end
      end
      rsp.entry_count = COUNT_W'(shadow_entries.size());
      rsp.is_empty = (shadow_entries.size() == 0);
      rsp.is_full = (shadow_entries.size() >= DEPTH);
      return rsp;
   endfunction

   task automatic send_item(input logic kind, input value_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_rsps.push_back(apply_queue_op(kind, value));
      items_sent++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      queue_rsp_type want;
      if (awaited_rsps.size() == 0) begin
         $display("%0t: result with none expected, actual tdata %h tuser %b",
                  $time, rsp_tdata, rsp_tuser);
         error_count++;
      end else begin
         want = awaited_rsps.pop_front();
         check_field("out_value", want.out_value, rsp_tdata[31:0]);
         check_field("status", want.status, rsp_tdata[33:32]);
         check_field("entry_count", want.entry_count, rsp_tdata[38:34]);
         check_field("is_empty", want.is_empty, rsp_tdata[39]);
         check_field("is_full", want.is_full, rsp_tdata[40]);
         check_field("padding", '0, rsp_tdata[RSP_DATA_W-1:41]);
         check_field("out_valid", want.out_valid, rsp_tuser);
         rsps_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL sorted_priority_queue");
      $finish;
   end

   task automatic test_directed_cases();
      value_type fill_values[16];
      fill_values = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1, 1, 5, 5, 5,
                      -5, 32'sh40000000, 32'shC0000000, 32'sh7FFFFFFF,
                      32'sh80000000, 2, -2, 0};
      send_item(KIND_DEQUEUE, 32'sh7FFFFFFF);
      foreach (fill_values[i]) send_item(KIND_ENQUEUE, fill_values[i]);
      send_item(KIND_ENQUEUE, 32'sh12345678);
      repeat (7) send_item(KIND_DEQUEUE, $urandom);
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2, 3, 4: return value_type'($urandom_range(6)) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned item_total);
      int unsigned enqueue_pct;
      int unsigned burst_left;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      burst_left = 0;
      enqueue_pct = 50;
      repeat (item_total) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 8);
            case ($urandom_range(2))
               0: enqueue_pct = 15;
               1: enqueue_pct = 50;
               default: enqueue_pct = 85;
            endcase
         end
         burst_left--;
         if ($urandom_range(99) < enqueue_pct) send_item(KIND_ENQUEUE, pick_value());
         else send_item(KIND_DEQUEUE, $urandom);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(0, 0, 300);
      test_random_traffic(85, 0, 300);
      test_random_traffic(0, 85, 300);
      test_random_traffic(9, 9, 300);
      req_tvalid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (awaited_rsps.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_rsps.size());
         error_count++;
      end
      $display("Sent %0d items and checked %0d results over four idling phases.",
               items_sent, rsps_checked);
      $display("Full refusals %0d, empty refusals %0d, queue filled %0d times, errors %0d.",
               full_refusals, empty_refusals, max_depth_hits, error_count);
      if (error_count == 0) begin
         $display("PASS sorted_priority_queue");
      end else begin
         $display("FAIL sorted_priority_queue");
      end
      $finish;
   end

endmodule

// ===== sorted_priority_queue.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
